>>> sv/isort_pkg.sv
`default_nettype none
package isort_pkg;

  localparam int DEPTH = 32;
  localparam int DW    = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef logic signed [DW-1:0] data_t;
  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        count_t;

  typedef struct packed {
    logic load_in;
    logic set_drop;
    logic rd_shift;
    logic wr_shift;
    logic wr_val;
    logic rd_emit;
    logic ld_out;
    logic inc_k;
    logic clr_set;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic pos_zero;
    logic greater;
    logic final_k;
  } stat_t;

endpackage
`default_nettype wire

>>> sv/isort_in_if.sv
`default_nettype none
interface isort_in_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::data_t     value;
  logic                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

>>> sv/isort_out_if.sv
`default_nettype none
interface isort_out_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::data_t     sorted_value;
  logic                 last_res;
  logic                 overflow;

  modport source (output valid, output sorted_value, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_res, input overflow,
                output ready);
endinterface
`default_nettype wire

>>> sv/isort_dp.sv
`default_nettype none
module isort_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire isort_pkg::cmd_t  cmd,
  output isort_pkg::stat_t      stat,
  input  wire isort_pkg::data_t in_value,
  input  wire logic             in_last,
  output isort_pkg::data_t      sorted_value,
  output logic                  last_res,
  output logic                  overflow
);

  isort_pkg::data_t  mem [isort_pkg::DEPTH];
  isort_pkg::data_t  rdata_r;
  isort_pkg::data_t  val_r;
  logic              last_r;
  isort_pkg::addr_t  pos_r;
  isort_pkg::addr_t  k_r;
  isort_pkg::count_t fill_r;
  logic              drop_r;
  isort_pkg::data_t  sorted_value_r;
  logic              last_res_r;
  logic              overflow_r;

  logic              we;
  isort_pkg::addr_t  raddr;
  isort_pkg::data_t  wdata;
  logic              final_k;

  assign we      = cmd.wr_shift | cmd.wr_val;
  assign wdata   = cmd.wr_shift ? rdata_r : val_r;
  assign raddr   = cmd.rd_emit ? k_r : pos_r - isort_pkg::addr_t'(1);
  assign final_k = (isort_pkg::count_t'(k_r) + isort_pkg::count_t'(1)) == fill_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_shift | cmd.rd_emit) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      drop_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        last_r <= in_last;
      end
      if (cmd.set_drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.wr_val) begin
        fill_r <= fill_r + isort_pkg::count_t'(1);
      end
      if (cmd.clr_set) begin
        fill_r <= '0;
        drop_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      val_r <= in_value;
      pos_r <= fill_r[isort_pkg::AW-1:0];
      k_r   <= '0;
    end else begin
      if (cmd.wr_shift) begin
        pos_r <= pos_r - isort_pkg::addr_t'(1);
      end
      if (cmd.inc_k) begin
        k_r <= k_r + isort_pkg::addr_t'(1);
      end
    end
    if (cmd.ld_out) begin
      sorted_value_r <= rdata_r;
      last_res_r     <= final_k;
      overflow_r     <= drop_r;
    end
  end

  assign stat.full     = fill_r == isort_pkg::count_t'(isort_pkg::DEPTH);
  assign stat.last     = last_r;
  assign stat.pos_zero = pos_r == '0;
  assign stat.greater  = rdata_r > val_r;
  assign stat.final_k  = final_k;

  assign sorted_value = sorted_value_r;
  assign last_res     = last_res_r;
  assign overflow     = overflow_r;

endmodule
`default_nettype wire

>>> sv/isort_ctrl.sv
`default_nettype none
module isort_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output isort_pkg::cmd_t       cmd,
  input  wire isort_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_CMP,
    S_EMRD,
    S_EMLD,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.full) begin
          cmd.set_drop = 1'b1;
          state_nxt    = stat.last ? S_EMRD : S_IDLE;
        end else if (stat.pos_zero) begin
          cmd.wr_val = 1'b1;
          state_nxt  = stat.last ? S_EMRD : S_IDLE;
        end else begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.greater) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_CHK;
        end else begin
          cmd.wr_val = 1'b1;
          state_nxt  = stat.last ? S_EMRD : S_IDLE;
        end
      end
      S_EMRD: begin
        cmd.rd_emit = 1'b1;
        state_nxt   = S_EMLD;
      end
      S_EMLD: begin
        cmd.ld_out = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (stat.final_k) begin
            cmd.clr_set = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.inc_k = 1'b1;
            state_nxt = S_EMRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_EMIT;

endmodule
`default_nettype wire

>>> sv/insertion_sorter_top.sv
// Stable ascending insertion sorter for sets of signed 32-bit values.
// Input channel in_ch: one value per request; last marks the final value of a set.
// Output channel out_ch: after the last value, the set comes out in ascending
// order, one request per value, last_res on the final one and overflow on all
// of them when more than DEPTH values arrived (the extra values are dropped).
// An input value is inserted by shifting each stored entry greater than it up
// one place; each shift is a store read step followed by a compare-and-write
// step, and the value is then written into the freed place. A dropped value is
// only checked against the full store.
// Each result passes through a store read, an output register load and a
// handshake, and the handshake waits while the receiver holds ready low.
// No input is taken while a value is being inserted or a set is being emitted.
// When the receiver stalls, the output register holds its result and the
// block waits. Synchronous active-low reset returns to idle with an empty
// set and a clear overflow flag; store contents need no clearing.
`default_nettype none
module insertion_sorter_top (
  input  wire logic    clk,
  input  wire logic    rst_n,
  isort_in_if.sink     in_ch,
  isort_out_if.source  out_ch
);

  isort_pkg::cmd_t  cmd;
  isort_pkg::stat_t stat;

  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  isort_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_value     (in_ch.value),
    .in_last      (in_ch.last),
    .sorted_value (out_ch.sorted_value),
    .last_res     (out_ch.last_res),
    .overflow     (out_ch.overflow)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_shift, cmd.wr_val}))
    else $error("two store writes in one cycle");

  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> !stat.pos_zero)
    else $error("shift below the bottom of the store");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=> out_ch.valid)
    else $error("loaded result not presented");

endmodule
`default_nettype wire
